@@ src/crrg_pkg.sv @@
// Shared constants, types and color packing helpers for the color ramp row generator.
package crrg_pkg;

   localparam int LEVELS_DEF    = 30;
   localparam int LEAD_MAX_DEF  = 15;
   localparam int FRAC_BITS_DEF = 16;

   localparam int CHAN_W     = 5;
   localparam int LEAD_W     = 4;
   localparam int IDX_W      = 5;
   localparam int COLOR_W    = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int RED_LSB    = 11;
   localparam int GREEN_LSB  = 6;
   localparam int BLUE_LSB   = 0;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 5'h1F;

   typedef logic [CHAN_W-1:0] chan_type;
   // Index 0 is red, 1 is green, 2 is blue.
   typedef chan_type [2:0] rgb_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [COLOR_W-1:0] pack_rgb(input rgb_type c);
      logic [COLOR_W-1:0] p;
      p = '0;
      p[RED_LSB +: CHAN_W]   = c[0];
      p[GREEN_LSB +: CHAN_W] = c[1];
      p[BLUE_LSB +: CHAN_W]  = c[2];
      return p;
   endfunction

   function automatic rgb_type unpack_rgb(input logic [COLOR_W-1:0] p);
      rgb_type c;
      c[0] = p[RED_LSB +: CHAN_W];
      c[1] = p[GREEN_LSB +: CHAN_W];
      c[2] = p[BLUE_LSB +: CHAN_W];
      return c;
   endfunction

endpackage

@@ src/color_ramp_row_generator.sv @@
// Color ramp row generator: sequencer, ramp accumulators and output register.
//
// One request item carries a seed color and a lead length L. The block answers with a
// row of LEVELS packed colors on the rsp channel, rsp_tlast set on the final one. The
// first L colors ramp toward the seed, starting from white when L is LEAD_MAX (that row
// is then kept as the base row) or else from entry LEAD_MAX-L of the base row, which is
// fetched in the cycle after the request is taken. The rest of the row ramps from the
// seed down to black.
// Each ramp segment first runs three slope divisions through one shared bit-serial
// divider, then emits its colors at up to one per cycle.
// req_tready is high only while no row is in progress, so one item is worked on at a time.
// A stall on rsp_tready holds the current color in the output register and pauses
// the emission; divisions still run. Reset empties the pipeline and clears the base row
// to black.
module color_ramp_row_generator #(
   parameter int LEVELS    = crrg_pkg::LEVELS_DEF,
   parameter int LEAD_MAX  = crrg_pkg::LEAD_MAX_DEF,
   parameter int FRAC_BITS = crrg_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // seed_red [4:0], seed_green [9:5], seed_blue [14:10], lead_steps [18:15], zeros above
   input  logic [crrg_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // packed_color [15:0], level_index [20:16], zeros above
   output logic [crrg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int CHAN_W = crrg_pkg::CHAN_W;
   localparam int LEAD_W = crrg_pkg::LEAD_W;
   localparam int ACC_W  = CHAN_W + FRAC_BITS;
   localparam int MAXN   = (LEVELS > LEAD_MAX) ? LEVELS : LEAD_MAX;
   localparam int CNT_W  = $clog2(MAXN + 1);
   localparam int POS_W  = $clog2(LEVELS);
   localparam int ADDR_W = (LEAD_MAX > 1) ? $clog2(LEAD_MAX) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_LOAD = 2'd3;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       chan_ff, chan_in;
   logic             div_go_ff, div_go_in;
   logic             white_ff, white_in;
   logic             seg2_ff, seg2_in;
   logic [LEAD_W-1:0] lead_ff, lead_in;
   crrg_pkg::rgb_type seed_ff, seed_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CHAN_W-1:0] mag_ff [3];
   logic [CHAN_W-1:0] mag_in [3];
   logic             neg_ff [3];
   logic             neg_in [3];
   logic [ACC_W-1:0] acc_ff [3];
   logic [ACC_W-1:0] acc_in [3];
   logic [ACC_W-1:0] slope_ff [3];
   logic [ACC_W-1:0] slope_in [3];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [crrg_pkg::COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic [crrg_pkg::IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic                          rsp_last_ff, rsp_last_in;

   // Request decode and lead clamping.
   crrg_pkg::rgb_type req_seed;
   logic [LEAD_W-1:0] req_lead_raw;
   logic [LEAD_W-1:0] req_lead;
   logic              req_white;
   logic              req_fire;

   // Base row port signals.
   logic                          base_wr_en;
   logic [ADDR_W-1:0]             base_wr_addr;
   logic [ADDR_W-1:0]             base_rd_addr;
   logic [crrg_pkg::COLOR_W-1:0]  base_rd_data;

   // Divider port signals.
   logic [ACC_W-1:0]              div_num;
   logic [CNT_W-1:0]              div_den;
   logic [ACC_W-1:0]              div_quot;
   crrg_pkg::div_status_type      div_stat;

   crrg_pkg::rgb_type emit_rgb;
   logic              out_free;
   logic              emit_fire;
   logic              emit_last;

   assign req_seed[0]  = req_tdata[4:0];
   assign req_seed[1]  = req_tdata[9:5];
   assign req_seed[2]  = req_tdata[14:10];
   assign req_lead_raw = req_tdata[18:15];

   always_comb begin
      if (req_lead_raw == '0) begin
         req_lead = LEAD_W'(1);
      end else if (32'(req_lead_raw) > LEAD_MAX) begin
         req_lead = LEAD_W'(LEAD_MAX);
      end else begin
         req_lead = req_lead_raw;
      end
   end

   assign req_white    = (32'(req_lead) == LEAD_MAX);
   assign req_tready   = (state_ff == ST_IDLE) && !reset;
   assign req_fire     = req_tvalid && req_tready;
   // The base row entry is captured at the accepting edge and used in the load cycle.
   assign base_rd_addr = ADDR_W'(LEAD_MAX - 32'(req_lead));

   assign div_num = {mag_ff[chan_ff], {FRAC_BITS{1'b0}}};
   assign div_den = n_ff - 1'b1;

   for (genvar c = 0; c < 3; c++) begin : g_emit
      assign emit_rgb[c] = acc_ff[c][ACC_W-1 -: CHAN_W];
   end

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_fire = (state_ff == ST_EMIT) && out_free;
   assign emit_last = (32'(pos_ff) == LEVELS - 1);

   assign base_wr_en   = emit_fire && white_ff && !seg2_ff && (32'(pos_ff) < LEAD_MAX);
   assign base_wr_addr = ADDR_W'(pos_ff);

   always_comb begin
      logic              setup;
      crrg_pkg::rgb_type seg_start;
      crrg_pkg::rgb_type seg_end;
      logic [CNT_W-1:0]  seg_n;

      state_in     = state_ff;
      chan_in      = chan_ff;
      div_go_in    = 1'b0;
      white_in     = white_ff;
      seg2_in      = seg2_ff;
      lead_in      = lead_ff;
      seed_in      = seed_ff;
      n_in         = n_ff;
      steps_in     = steps_ff;
      pos_in       = pos_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      slope_in     = slope_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_color_in = rsp_color_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      setup        = 1'b0;
      seg_start    = '0;
      seg_end      = '0;
      seg_n        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               white_in = req_white;
               seg2_in  = 1'b0;
               lead_in  = req_lead;
               seed_in  = req_seed;
               pos_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            setup   = 1'b1;
            seg_end = seed_ff;
            seg_n   = CNT_W'(lead_ff);
            if (white_ff) begin
               seg_start = {crrg_pkg::CHAN_MAX, crrg_pkg::CHAN_MAX, crrg_pkg::CHAN_MAX};
            end else begin
               seg_start = crrg_pkg::unpack_rgb(base_rd_data);
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               // A one-step ramp has a zero divisor and keeps a flat slope.
               slope_in[chan_ff] = (n_ff == CNT_W'(1)) ? '0 : div_quot;
               if (chan_ff == CH_BLUE) begin
                  state_in = ST_EMIT;
               end else begin
                  chan_in   = chan_ff + 1'b1;
                  div_go_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = crrg_pkg::pack_rgb(emit_rgb);
               rsp_idx_in   = crrg_pkg::IDX_W'(pos_ff);
               rsp_last_in  = emit_last;
               for (int c = 0; c < 3; c++) begin
                  acc_in[c] = neg_ff[c] ? (acc_ff[c] - slope_ff[c])
                                        : (acc_ff[c] + slope_ff[c]);
               end
               steps_in = steps_ff - 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  if (steps_ff == CNT_W'(1)) begin
                     // Lead segment done: ramp from the seed down to black.
                     seg2_in   = 1'b1;
                     setup     = 1'b1;
                     seg_start = seed_ff;
                     seg_end   = '0;
                     seg_n     = CNT_W'(LEVELS - 32'(lead_ff));
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (setup) begin
         for (int c = 0; c < 3; c++) begin
            acc_in[c] = {seg_start[c], {FRAC_BITS{1'b0}}};
            neg_in[c] = (seg_start[c] > seg_end[c]);
            mag_in[c] = (seg_start[c] > seg_end[c]) ? (seg_start[c] - seg_end[c])
                                                    : (seg_end[c] - seg_start[c]);
         end
         n_in      = seg_n;
         steps_in  = seg_n;
         chan_in   = CH_RED;
         div_go_in = 1'b1;
         state_in  = ST_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= CH_RED;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      white_ff     <= white_in;
      seg2_ff      <= seg2_in;
      lead_ff      <= lead_in;
      seed_ff      <= seed_in;
      n_ff         <= n_in;
      steps_ff     <= steps_in;
      pos_ff       <= pos_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      acc_ff       <= acc_in;
      slope_ff     <= slope_in;
      rsp_color_ff <= rsp_color_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_last_ff  <= rsp_last_in;
   end

   crrg_divider #(
      .NUM_W (ACC_W),
      .DEN_W (CNT_W)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_go_ff),
      .num    (div_num),
      .den    (div_den),
      .quot   (div_quot),
      .status (div_stat)
   );

   crrg_base_row #(
      .LEAD_MAX (LEAD_MAX),
      .ADDR_W   (ADDR_W)
   ) u_base_row (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (base_wr_en),
      .wr_addr (base_wr_addr),
      .wr_data (crrg_pkg::pack_rgb(emit_rgb)),
      .rd_addr (base_rd_addr),
      .rd_data (base_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = crrg_pkg::RSP_DATA_W'({rsp_idx_ff, rsp_color_ff});

   // A division is only ever launched while the sequencer waits on it.
   a_div_go_in_div: assert property (@(posedge clock) disable iff (reset)
      div_go_ff |-> (state_ff == ST_DIV))
      else $error("divider started outside the division phase");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the division phase");

   a_go_when_free: assert property (@(posedge clock) disable iff (reset)
      div_go_ff |-> !div_stat.busy)
      else $error("division launched while the divider is busy");

   a_emit_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (steps_ff != '0))
      else $error("emitting with no steps left in the segment");

   a_last_ends_row: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && emit_last) |=> ((state_ff == ST_IDLE) && rsp_tvalid && rsp_tlast))
      else $error("row still in progress after its last item");

endmodule

@@ src/crrg_divider.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module crrg_divider #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           num,
   input  logic [DEN_W-1:0]           den,
   output logic [NUM_W-1:0]           quot,
   output crrg_pkg::div_status_type   status
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_diff;
   logic             ge;

   assign rem_sh   = {rem_ff, num_ff[NUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign ge       = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      num_in  = num_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[NUM_W-2:0], ge};
         rem_in  = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
   end

   assign quot        = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ src/crrg_base_row.sv @@
// Stored base row of packed colors, cleared to black at reset.
module crrg_base_row #(
   parameter int LEAD_MAX = crrg_pkg::LEAD_MAX_DEF,
   parameter int ADDR_W   = (LEAD_MAX > 1) ? $clog2(LEAD_MAX) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [crrg_pkg::COLOR_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [crrg_pkg::COLOR_W-1:0]  rd_data
);

   logic [crrg_pkg::COLOR_W-1:0] row_ff [LEAD_MAX];
   logic [crrg_pkg::COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEAD_MAX; i++) begin
            row_ff[i] <= '0;
         end
      end else if (wr_en) begin
         row_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= row_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
